### rtl/core/trms_pkg.sv
// Shared types and constants for the test-rig mode sequencer.
// Depends on nothing; used by every other file of the block.
package trms_pkg;

    // Motor command codes
    typedef enum logic [2:0] {
        CMD_NONE      = 3'd0,
        CMD_STOP      = 3'd1,
        CMD_STEP_UP   = 3'd2,
        CMD_STEP_DOWN = 3'd3,
        CMD_HOLD_UP   = 3'd4,
        CMD_HOLD_DOWN = 3'd5,
        CMD_RUN_PULL  = 3'd6,
        CMD_RUN_PUSH  = 3'd7
    } t_cmd;

    // Machine state codes
    typedef enum logic [1:0] {
        ST_READY   = 2'd0,
        ST_RUNNING = 2'd1,
        ST_STOP    = 2'd2
    } t_mstate;

    localparam logic MODE_PULL = 1'b0;
    localparam logic MODE_PUSH = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_INITIAL_FORCE = 2'd0;
    localparam logic [1:0] CFG_FORCE_RATE    = 2'd1;
    localparam logic [1:0] CFG_MAX_FORCE     = 2'd2;

    localparam int FORCE_W   = 24;
    localparam int RATE_W    = 12;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 24;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    localparam logic [FORCE_W-1:0] INITIAL_FORCE_RST = 24'd0;
    localparam logic [RATE_W-1:0]  FORCE_RATE_RST    = 12'd12;
    localparam logic [FORCE_W-1:0] MAX_FORCE_RST     = 24'd1000000;

    // One control-loop pass
    typedef struct packed {
        logic              reset_press;
        logic              start_on;
        logic              mode_change_req;
        logic              mode_dir_down;
        logic              up_press;
        logic              down_press;
        logic              up_long;
        logic              down_long;
        logic              up_level;
        logic              down_level;
        logic              motor_busy;
        logic [TIME_W-1:0] now_ms;
    } t_item;

    // Sequencer state carried from pass to pass
    typedef struct packed {
        logic [FORCE_W-1:0] force_val;
        logic               mode;
        t_mstate            st;
        logic               hold;
        logic [TIME_W-1:0]  last_ms;
    } t_seq_state;

    // Configuration register set
    typedef struct packed {
        logic [FORCE_W-1:0] initial_force;
        logic [RATE_W-1:0]  force_rate;
        logic [FORCE_W-1:0] max_force;
    } t_cfg;

endpackage

### rtl/core/trms_force.sv
// Force growth unit: force + elapsed * rate, saturated at the maximum.
// Depends on trms_pkg for field widths.
module trms_force (
    input  logic [trms_pkg::FORCE_W-1:0] i_force,
    input  logic [trms_pkg::TIME_W-1:0]  i_elapsed,
    input  logic [trms_pkg::RATE_W-1:0]  i_rate,
    input  logic [trms_pkg::FORCE_W-1:0] i_max,
    output logic [trms_pkg::FORCE_W-1:0] o_force
);

    localparam int PROD_W = trms_pkg::TIME_W + trms_pkg::RATE_W;
    localparam int SUM_W  = PROD_W + 1;

    logic [PROD_W-1:0] w_prod;
    logic [SUM_W-1:0]  w_sum;

    // 32x12 product, then one wide add and compare
    assign w_prod = {{trms_pkg::RATE_W{1'b0}}, i_elapsed} * {{trms_pkg::TIME_W{1'b0}}, i_rate};
    assign w_sum  = {{(SUM_W-trms_pkg::FORCE_W){1'b0}}, i_force} + {1'b0, w_prod};

    assign o_force = (w_sum >= {{(SUM_W-trms_pkg::FORCE_W){1'b0}}, i_max})
                   ? i_max : w_sum[trms_pkg::FORCE_W-1:0];

endmodule

### rtl/core/trms_step.sv
// Next-state and command logic for one control-loop pass.
// Depends on trms_pkg and trms_force.
module trms_step (
    input  trms_pkg::t_item      i_item,
    input  trms_pkg::t_seq_state i_state,
    input  trms_pkg::t_cfg       i_cfg,
    output trms_pkg::t_seq_state o_state,
    output trms_pkg::t_cmd       o_cmd
);

    logic [trms_pkg::TIME_W-1:0]  w_elapsed;
    logic [trms_pkg::FORCE_W-1:0] w_grown;

    assign w_elapsed = i_item.now_ms - i_state.last_ms;

    trms_force u_force (
        .i_force   (i_state.force_val),
        .i_elapsed (w_elapsed),
        .i_rate    (i_cfg.force_rate),
        .i_max     (i_cfg.max_force),
        .o_force   (w_grown)
    );

    // Decision tree of one pass
    always_comb begin
        logic busy;
        busy    = i_item.motor_busy;
        o_state = i_state;
        o_cmd   = trms_pkg::CMD_NONE;

        if (i_item.reset_press && (i_state.force_val > i_cfg.initial_force)) begin
            // reset press restores the initial force
            o_cmd             = trms_pkg::CMD_STOP;
            o_state.hold      = 1'b0;
            o_state.force_val = i_cfg.initial_force;
            o_state.last_ms   = i_item.now_ms;
            o_state.st        = i_item.start_on ? trms_pkg::ST_STOP : trms_pkg::ST_READY;
        end else if (i_item.reset_press && !i_item.start_on) begin
            // reset press with start off toggles the mode
            o_cmd        = trms_pkg::CMD_STOP;
            o_state.hold = 1'b0;
            o_state.mode = ~i_state.mode;
            o_state.st   = trms_pkg::ST_READY;
        end else if (!i_item.start_on) begin
            // manual operation
            if (busy && (i_state.st == trms_pkg::ST_RUNNING)) begin
                o_cmd           = trms_pkg::CMD_STOP;
                o_state.st      = trms_pkg::ST_STOP;
                o_state.last_ms = i_item.now_ms;
            end
            if (i_item.up_press) begin
                o_state.hold = 1'b0;
                o_cmd        = trms_pkg::CMD_STEP_UP;
                o_state.st   = trms_pkg::ST_READY;
            end else if (i_item.down_press) begin
                o_state.hold = 1'b0;
                o_cmd        = trms_pkg::CMD_STEP_DOWN;
                o_state.st   = trms_pkg::ST_READY;
            end else if (i_item.up_long) begin
                o_state.hold = 1'b1;
                o_cmd        = trms_pkg::CMD_HOLD_UP;
                o_state.st   = trms_pkg::ST_READY;
            end else if (i_item.down_long) begin
                o_state.hold = 1'b1;
                o_cmd        = trms_pkg::CMD_HOLD_DOWN;
                o_state.st   = trms_pkg::ST_READY;
            end else if (i_state.hold && !i_item.up_level && !i_item.down_level) begin
                o_state.hold = 1'b0;
                o_cmd        = trms_pkg::CMD_STOP;
            end
        end else begin
            // automatic run
            if (i_item.mode_change_req) begin
                o_state.mode    = i_item.mode_dir_down ? trms_pkg::MODE_PULL
                                                       : trms_pkg::MODE_PUSH;
                o_cmd           = trms_pkg::CMD_STOP;
                busy            = 1'b0;
                o_state.hold    = 1'b0;
                o_state.st      = trms_pkg::ST_READY;
                o_state.last_ms = i_item.now_ms;
            end
            if ((o_state.st != trms_pkg::ST_RUNNING) || !busy) begin
                // (re)start the motor; elapsed time is zero afterwards
                o_cmd           = (o_state.mode == trms_pkg::MODE_PULL)
                                ? trms_pkg::CMD_RUN_PULL : trms_pkg::CMD_RUN_PUSH;
                o_state.st      = trms_pkg::ST_RUNNING;
                o_state.last_ms = i_item.now_ms;
            end else if (w_elapsed != '0) begin
                o_state.force_val = w_grown;
                o_state.last_ms   = i_item.now_ms;
            end
        end
    end

endmodule

### rtl/core/test_rig_mode_sequencer_core.sv
// Top level of the test-rig mode sequencer: input register, state, result register.
// Depends on trms_pkg and trms_step (which holds trms_force).
//
//  channel   direction  handshake                 payload
//  s_axis    in         i_s_tvalid / o_s_tready   i_s_tdata  (one control pass)
//  m_axis    out        o_m_tvalid / i_m_tready   o_m_tdata  (one result)
//  cfg       in         i_cfg_we                  i_cfg_addr, i_cfg_wdata
//
// A request is loaded into the input register when accepted; its result and the
// next state are then loaded into the result and state registers once the result
// register can advance. One request is accepted per clock unless a stalled result
// and a full input register hold it off.
// Synchronous active-low reset clears state and both valid flags and loads the config defaults.
// A stalled result holds; the input register still fills behind it.
module test_rig_mode_sequencer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // fields from bit 0: reset_press, start_on, mode_change_req, mode_dir_down,
    // up_press, down_press, up_long, down_long, up_level, down_level,
    // motor_busy, now_ms[31:0] (bits 42:11), zero fill
    input  logic [trms_pkg::IN_DATA_W-1:0]    i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // fields from bit 0: motor_cmd[2:0], force_value[23:0], mode_out,
    // machine_state[1:0], zero fill
    output logic [trms_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_addr,
    input  logic [trms_pkg::CFG_W-1:0]        i_cfg_wdata
);

    logic                 r_in_valid;
    trms_pkg::t_item      r_in;
    logic                 r_out_valid;
    logic [trms_pkg::OUT_DATA_W-1:0] r_out_data;
    trms_pkg::t_seq_state r_state;
    trms_pkg::t_cfg       r_cfg;

    trms_pkg::t_seq_state n_state;
    trms_pkg::t_cmd       n_cmd;
    trms_pkg::t_item      w_item;
    logic                 w_advance;
    logic                 w_s_ready;

    // Unpack the input request
    assign w_item = {i_s_tdata[0], i_s_tdata[1], i_s_tdata[2], i_s_tdata[3],
                     i_s_tdata[4], i_s_tdata[5], i_s_tdata[6], i_s_tdata[7],
                     i_s_tdata[8], i_s_tdata[9], i_s_tdata[10], i_s_tdata[42:11]};

    assign w_advance  = !r_out_valid || i_m_tready;
    assign w_s_ready  = !r_in_valid || w_advance;
    assign o_s_tready = i_rst_n && w_s_ready;

    trms_step u_step (
        .i_item  (r_in),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_cmd   (n_cmd)
    );

    // Control, state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
            r_state.force_val   <= trms_pkg::INITIAL_FORCE_RST;
            r_state.mode        <= trms_pkg::MODE_PULL;
            r_state.st          <= trms_pkg::ST_READY;
            r_state.hold        <= 1'b0;
            r_state.last_ms     <= '0;
            r_cfg.initial_force <= trms_pkg::INITIAL_FORCE_RST;
            r_cfg.force_rate    <= trms_pkg::FORCE_RATE_RST;
            r_cfg.max_force     <= trms_pkg::MAX_FORCE_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    trms_pkg::CFG_INITIAL_FORCE: r_cfg.initial_force <= i_cfg_wdata;
                    trms_pkg::CFG_FORCE_RATE:
                        r_cfg.force_rate <= i_cfg_wdata[trms_pkg::RATE_W-1:0];
                    trms_pkg::CFG_MAX_FORCE:     r_cfg.max_force <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_s_ready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_s_ready && i_s_tvalid) begin
            r_in <= w_item;
        end
        if (w_advance && r_in_valid) begin
            r_out_data <= {2'b00, n_state.st, n_state.mode, n_state.force_val, n_cmd};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

### rtl/core/trms_checker.sv
// Port-level checks for the test-rig mode sequencer, bound to the top level.
// Depends on trms_pkg and test_rig_mode_sequencer_core.
module trms_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [trms_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    // a stalled result holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // no result straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // machine state is never the unused code
    a_state_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[29:28] != 2'd3)
        else $error("unused machine state code");

    // a run command leaves the machine running in the matching mode
    a_run_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[2:0] == trms_pkg::CMD_RUN_PULL
                    || o_m_tdata[2:0] == trms_pkg::CMD_RUN_PUSH)
        |-> o_m_tdata[29:28] == trms_pkg::ST_RUNNING
            && o_m_tdata[27] == (o_m_tdata[2:0] == trms_pkg::CMD_RUN_PUSH))
        else $error("run command without running state or matching mode");

    // manual step and hold commands leave the machine ready
    a_manual_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[2:0] == trms_pkg::CMD_STEP_UP
                    || o_m_tdata[2:0] == trms_pkg::CMD_STEP_DOWN
                    || o_m_tdata[2:0] == trms_pkg::CMD_HOLD_UP
                    || o_m_tdata[2:0] == trms_pkg::CMD_HOLD_DOWN)
        |-> o_m_tdata[29:28] == trms_pkg::ST_READY)
        else $error("manual command without ready state");

endmodule

bind test_rig_mode_sequencer_core trms_checker u_trms_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
